### sv/utf8d_pkg.sv
`timescale 1ns / 1ps

package utf8d_pkg;

	localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

	// result queue between the decode stage and the output port
	localparam int BUF_DEPTH = 4;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);

	typedef enum logic [1:0] {
		PHASE_IDLE    = 2'd0,
		PHASE_COLLECT = 2'd1,
		PHASE_SWALLOW = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [1:0] bytes_following;
	} byte_item_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic        last_of_run;
	} cp_item_t;

	// results of one decoded byte; push1 only ever comes with push0
	typedef struct packed {
		logic     push0;
		logic     push1;
		cp_item_t res0;
		cp_item_t res1;
	} push_t;

endpackage

### sv/utf8d_core.sv
`timescale 1ns / 1ps

module utf8d_core import utf8d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  byte_item_t in_item,
	input  logic       room,
	output push_t      push
);

	typedef struct packed {
		logic        emit;
		logic [20:0] cp;
		phase_t      phase;
		logic [1:0]  needed;
		logic [20:0] partial;
	} lead_t;

	logic       valid_s1;
	byte_item_t item_s1;
	logic       advance;

	phase_t      phase_q, phase_d;
	logic [1:0]  needed_q, needed_d;
	logic [1:0]  seen_q, seen_d;
	logic [20:0] partial_q, partial_d;

	lead_t       lead;
	logic [1:0]  seen_inc;
	logic [20:0] partial_sh;

	function automatic lead_t lead_decode(input logic [7:0] b, input logic [1:0] follow);
		lead_t      r;
		logic [1:0] cnt;
		logic       bad;
		r.emit    = 1'b1;
		r.cp      = REPLACEMENT_CP;
		r.phase   = PHASE_IDLE;
		r.needed  = 2'd0;
		r.partial = '0;
		cnt       = 2'd0;
		bad       = 1'b0;
		priority if (b[7:5] == 3'b110) begin
			cnt = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			cnt = 2'd2;
		end else if (b[7:3] == 5'b11110) begin
			cnt = 2'd3;
		end else begin
			bad = 1'b1;
		end
		if (!b[7]) begin
			r.cp = {14'd0, b[6:0]};
		end else if (bad) begin
			r.cp = REPLACEMENT_CP;
		end else if (follow < cnt) begin
			// truncated: drop the rest of the string unless this was its end
			r.phase = (follow == 2'd0) ? PHASE_IDLE : PHASE_SWALLOW;
		end else begin
			r.emit   = 1'b0;
			r.phase  = PHASE_COLLECT;
			r.needed = cnt;
			unique case (cnt)
				2'd1:    r.partial = {16'd0, b[4:0]};
				2'd2:    r.partial = {17'd0, b[3:0]};
				default: r.partial = {18'd0, b[2:0]};
			endcase
		end
		return r;
	endfunction

	assign advance  = valid_s1 & room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PHASE_IDLE;
			needed_q  <= 2'd0;
			seen_q    <= 2'd0;
			partial_q <= '0;
		end else if (advance) begin
			phase_q   <= phase_d;
			needed_q  <= needed_d;
			seen_q    <= seen_d;
			partial_q <= partial_d;
		end
	end

	assign lead       = lead_decode(item_s1.data_byte, item_s1.bytes_following);
	assign seen_inc   = seen_q + 2'd1;
	assign partial_sh = {partial_q[14:0], item_s1.data_byte[5:0]};

	always_comb begin
		phase_d   = phase_q;
		needed_d  = needed_q;
		seen_d    = seen_q;
		partial_d = partial_q;
		push.push0 = 1'b0;
		push.push1 = 1'b0;
		push.res0  = '{code_point: REPLACEMENT_CP, last_of_run: 1'b1};
		push.res1  = '{code_point: lead.cp, last_of_run: 1'b1};
		unique case (phase_q)
			PHASE_SWALLOW: begin
				if (item_s1.bytes_following == 2'd0) begin
					phase_d = PHASE_IDLE;
				end
			end
			PHASE_COLLECT: begin
				if (item_s1.data_byte[7:6] != 2'b10) begin
					// bad tail: replacement, then the byte starts over as a lead
					push.push0 = 1'b1;
					push.push1 = lead.emit;
					push.res0.last_of_run = !lead.emit;
					phase_d = lead.phase;
					if (lead.phase == PHASE_COLLECT) begin
						needed_d  = lead.needed;
						seen_d    = 2'd0;
						partial_d = lead.partial;
					end
				end else begin
					partial_d = partial_sh;
					seen_d    = seen_inc;
					if (seen_inc == needed_q) begin
						phase_d    = PHASE_IDLE;
						push.push0 = 1'b1;
						push.res0.code_point = partial_sh;
					end else if (item_s1.bytes_following == 2'd0) begin
						phase_d    = PHASE_IDLE;
						push.push0 = 1'b1;
					end
				end
			end
			default: begin
				push.push0 = lead.emit;
				push.res0.code_point = lead.cp;
				phase_d = lead.phase;
				if (lead.phase == PHASE_COLLECT) begin
					needed_d  = lead.needed;
					seen_d    = 2'd0;
					partial_d = lead.partial;
				end
			end
		endcase
		if (!advance) begin
			push.push0 = 1'b0;
			push.push1 = 1'b0;
		end
	end

endmodule

### sv/utf8d_obuf.sv
`timescale 1ns / 1ps

module utf8d_obuf import utf8d_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  push_t    push,
	output logic     room,
	output logic     out_valid,
	input  logic     out_ready,
	output cp_item_t out_item
);

	cp_item_t          mem_q [BUF_DEPTH];
	logic [BUF_AW-1:0] wr_q, rd_q;
	logic [BUF_AW:0]   cnt_q;
	logic [1:0]        npush;
	logic              pop;

	assign npush     = {1'b0, push.push0} + {1'b0, push.push1};
	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != '0;
	assign out_item  = mem_q[rd_q];
	// two free slots needed since one byte can give two results
	assign room      = cnt_q <= (BUF_AW+1)'(BUF_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wr_q] <= push.res0;
		end
		if (push.push1) begin
			mem_q[wr_q + BUF_AW'(1)] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + BUF_AW'(npush);
			rd_q  <= rd_q + BUF_AW'(pop);
			cnt_q <= cnt_q + (BUF_AW+1)'(npush) - (BUF_AW+1)'(pop);
		end
	end

endmodule

### sv/utf8_stream_decoder.sv
`timescale 1ns / 1ps

// UTF-8 stream decoder: one byte in per transaction, code points out.
// Input channel byte_valid/byte_ready carries byte_item: data_byte and
// bytes_following (bytes of the string after this one, saturated at 3;
// zero marks the string end). Output channel cp_valid/cp_ready carries
// cp_item: the code point (U+FFFD for malformed or truncated sequences)
// and last_of_run, set on the final result caused by an input byte.
// Throughput: one byte per cycle while the queue has room. A byte gives
// zero, one or two results; two results of one byte enter the queue
// together and leave it through the single output port, one result per
// cycle while cp_ready is high. A byte is held in the input stage
// register, then its results enter a 4-entry result queue driving cp_item.
// Reset (arst_n low) empties the pipeline and queue and returns the decoder
// to idle. When the receiver stalls, the queue fills; while fewer than two
// entries are free a byte in the input stage waits there and byte_ready
// stays low. Nothing is lost.

module utf8_stream_decoder import utf8d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  byte_item_t byte_item,
	output logic       cp_valid,
	input  logic       cp_ready,
	output cp_item_t   cp_item
);

	push_t push;
	logic  room;

	utf8d_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (byte_valid),
		.in_ready (byte_ready),
		.in_item  (byte_item),
		.room     (room),
		.push     (push)
	);

	utf8d_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (cp_valid),
		.out_ready (cp_ready),
		.out_item  (cp_item)
	);

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.push1 |-> push.push0)
		else $error("second result pushed without first");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.push0 |-> room)
		else $error("result pushed into full queue");

	a_pair_first: assert property (@(posedge clk) disable iff (!arst_n)
		push.push1 |-> (push.res0.code_point == REPLACEMENT_CP && !push.res0.last_of_run
			&& push.res1.last_of_run))
		else $error("bad result pair");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!room |-> !push.push0)
		else $error("push while stalled");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import utf8d_pkg::*;

	localparam int LIVE_ITEMS  = 1150;
	localparam int CYCLE_LIMIT = 200000;

	logic       clk;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_ready;
	byte_item_t byte_item;
	logic       cp_valid;
	logic       cp_ready;
	cp_item_t   cp_item;

	// decoder state as predicted from the accepted bytes
	phase_t      dec_phase = PHASE_IDLE;
	int          tails_need = 0;
	int          tails_got  = 0;
	logic [20:0] cp_acc     = '0;

	cp_item_t    expected_cps[$];
	logic [7:0]  text_q[$];
	int          live_items   = 0;
	int          errors       = 0;
	int          hold_request = 0;
	bit          no_idle      = 1'b0;
	int          cycles;

	utf8_stream_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item (byte_item),
		.cp_valid  (cp_valid),
		.cp_ready  (cp_ready),
		.cp_item   (cp_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void expect_cp(input logic [20:0] cp, input logic last);
		cp_item_t r;
		r.code_point  = cp;
		r.last_of_run = last;
		expected_cps.insert(expected_cps.size(), r);
	endfunction

	// treats the byte as a fresh lead; returns how many code points it produced
	function automatic int begin_sequence(input logic [7:0] b, input logic [1:0] f);
		int cnt;
		if (!b[7]) begin
			dec_phase = PHASE_IDLE;
			expect_cp({14'd0, b[6:0]}, 1'b1);
			return 1;
		end
		if (b[7:5] == 3'b110)
			cnt = 1;
		else if (b[7:4] == 4'b1110)
			cnt = 2;
		else if (b[7:3] == 5'b11110)
			cnt = 3;
		else begin
			dec_phase = PHASE_IDLE;
			expect_cp(REPLACEMENT_CP, 1'b1);
			return 1;
		end
		if (int'(f) < cnt) begin
			dec_phase = (f == 2'd0) ? PHASE_IDLE : PHASE_SWALLOW;
			expect_cp(REPLACEMENT_CP, 1'b1);
			return 1;
		end
		dec_phase  = PHASE_COLLECT;
		tails_need = cnt;
		tails_got  = 0;
		cp_acc     = 21'(b & (8'h7F >> (cnt + 1)));
		return 0;
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic [1:0] f);
		cp_item_t fix;
		case (dec_phase)
			PHASE_SWALLOW: begin
				if (f == 2'd0)
					dec_phase = PHASE_IDLE;
			end
			PHASE_COLLECT: begin
				if (b[7:6] != 2'b10) begin
					dec_phase = PHASE_IDLE;
					expect_cp(REPLACEMENT_CP, 1'b0);
					// byte restarted a sequence without output: the U+FFFD is last
					if (begin_sequence(b, f) == 0) begin
						fix = expected_cps.pop_back();
						expect_cp(fix.code_point, 1'b1);
					end
				end else begin
					cp_acc    = {cp_acc[14:0], b[5:0]};
					tails_got = tails_got + 1;
					if (tails_got == tails_need) begin
						dec_phase = PHASE_IDLE;
						expect_cp(cp_acc, 1'b1);
					end else if (f == 2'd0) begin
						dec_phase = PHASE_IDLE;
						expect_cp(REPLACEMENT_CP, 1'b1);
					end
				end
			end
			default: void'(begin_sequence(b, f));
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic [1:0] f);
		int gap;
		byte_item_t item;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.data_byte       = b;
		item.bytes_following = f;
		byte_valid <= 1'b1;
		byte_item  <= item;
		do @(posedge clk); while (!byte_ready);
		if (dec_phase != PHASE_SWALLOW)
			live_items++;
		decode_byte(b, f);
	endtask

	function automatic void queue_byte(input logic [7:0] b);
		text_q.insert(text_q.size(), b);
	endfunction

	// lead of a len-byte character followed by ntails random tails
	function automatic void add_char(input int len, input int ntails);
		case (len)
			1: queue_byte({1'b0, 7'($urandom)});
			2: queue_byte({3'b110, 5'($urandom)});
			3: queue_byte({4'b1110, 4'($urandom)});
			default: queue_byte({5'b11110, 3'($urandom)});
		endcase
		for (int i = 0; i < ntails; i++)
			queue_byte({2'b10, 6'($urandom)});
	endfunction

	function automatic void add_chars(input int n);
		int len;
		for (int i = 0; i < n; i++) begin
			len = $urandom_range(1, 4);
			add_char(len, len - 1);
		end
	endfunction

	task automatic send_text();
		int rem;
		for (int i = 0; i < text_q.size(); i++) begin
			rem = text_q.size() - 1 - i;
			send_byte(text_q[i], (rem > 3) ? 2'd3 : 2'(rem));
		end
		text_q.delete();
	endtask

	task automatic test_ascii();
		send_byte(8'h00, 2'd0);
		send_byte(8'h7F, 2'd0);
	endtask

	task automatic test_multibyte();
		send_byte(8'hC2, 2'd1);
		send_byte(8'hA9, 2'd0);
		send_byte(8'hE2, 2'd2);
		send_byte(8'h82, 2'd1);
		send_byte(8'hAC, 2'd0);
		send_byte(8'hF0, 2'd3);
		send_byte(8'h9F, 2'd2);
		send_byte(8'h98, 2'd1);
		send_byte(8'h80, 2'd0);
		// largest value a 4-byte form can carry
		send_byte(8'hF7, 2'd3);
		send_byte(8'hBF, 2'd2);
		send_byte(8'hBF, 2'd1);
		send_byte(8'hBF, 2'd0);
	endtask

	task automatic test_bad_lead();
		send_byte(8'h80, 2'd0);
		send_byte(8'hFF, 2'd0);
	endtask

	// short lead: rest of the string is dropped, even bytes that look like a new one
	task automatic test_truncated();
		send_byte(8'hC3, 2'd0);
		send_byte(8'hE2, 2'd1);
		send_byte(8'h41, 2'd2);
		send_byte(8'h42, 2'd0);
		send_byte(8'h43, 2'd0);
	endtask

	task automatic test_bad_continuation();
		send_byte(8'hC3, 2'd1);
		send_byte(8'h41, 2'd0);
		send_byte(8'hE2, 2'd3);
		send_byte(8'hC3, 2'd1);
		send_byte(8'hA9, 2'd0);
	endtask

	// valid tail marked as string end before the sequence is complete
	task automatic test_early_end();
		send_byte(8'hE2, 2'd2);
		send_byte(8'h82, 2'd0);
	endtask

	task automatic test_pressure();
		no_idle      = 1'b1;
		hold_request = 200;
		for (int i = 0; i < 40; i++)
			send_byte({1'b0, 7'($urandom)}, 2'd0);
		no_idle = 1'b0;
	endtask

	task automatic test_random();
		int kind;
		int len;
		while (live_items < LIVE_ITEMS) begin
			if ($urandom_range(0, 15) == 0)
				no_idle = !no_idle;
			kind = $urandom_range(0, 9);
			if (kind == 9) begin
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom), 2'($urandom));
			end else begin
				if (kind <= 5) begin
					add_chars($urandom_range(1, 7));
				end else begin
					add_chars($urandom_range(0, 3));
					if (kind == 8) begin
						if ($urandom_range(0, 1))
							queue_byte({2'b10, 6'($urandom)});
						else
							queue_byte({5'b11111, 3'($urandom)});
					end else begin
						len = $urandom_range(2, 4);
						add_char(len, $urandom_range(0, len - 2));
					end
					if (kind != 6)
						add_chars($urandom_range(1, 3));
				end
				send_text();
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin : receiver
		int stall;
		cp_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				cp_ready <= 1'b0;
				repeat (hold_request) @(posedge clk);
				hold_request = 0;
			end
			stall = no_idle ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				cp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			cp_ready <= 1'b1;
			do @(posedge clk); while (!(cp_valid && cp_ready));
		end
	end

	always @(posedge clk) begin : check_cp
		cp_item_t want;
		if (arst_n && cp_valid && cp_ready) begin
			if (expected_cps.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected code point %h last %b",
						cp_item.code_point, cp_item.last_of_run);
			end else begin
				want = expected_cps.pop_front();
				if (cp_item.code_point !== want.code_point ||
						cp_item.last_of_run !== want.last_of_run) begin
					errors++;
					if (errors <= 10)
						$display("code point: expected %h last %b, got %h last %b",
							want.code_point, want.last_of_run,
							cp_item.code_point, cp_item.last_of_run);
				end
			end
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("utf8_stream_decoder: mismatch");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		byte_item  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_ascii();
		test_multibyte();
		test_bad_lead();
		test_truncated();
		test_bad_continuation();
		test_early_end();
		test_pressure();
		test_random();
		byte_valid <= 1'b0;
		while (expected_cps.size() != 0)
			@(posedge clk);
		// catch stray results after the last expected one
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_cps.size() == 0)
			$display("utf8_stream_decoder: match");
		else
			$display("utf8_stream_decoder: mismatch");
		$finish;
	end

endmodule

### filelist.f
sv/utf8d_pkg.sv
sv/utf8d_core.sv
sv/utf8d_obuf.sv
sv/utf8_stream_decoder.sv
bench/tb.sv
